[design/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// types, token codes and character classes for the source token lexer
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned PosBits         = 16;
  localparam int unsigned MaxCommentDepth = 15;
  localparam int unsigned DepthBits       = 8;

  localparam logic [4:0] KindLparen   = 5'd0;
  localparam logic [4:0] KindRparen   = 5'd1;
  localparam logic [4:0] KindLbrace   = 5'd2;
  localparam logic [4:0] KindRbrace   = 5'd3;
  localparam logic [4:0] KindLbrack   = 5'd4;
  localparam logic [4:0] KindRbrack   = 5'd5;
  localparam logic [4:0] KindSemi     = 5'd6;
  localparam logic [4:0] KindColCol   = 5'd8;
  localparam logic [4:0] KindColEq    = 5'd9;
  localparam logic [4:0] KindComma    = 5'd10;
  localparam logic [4:0] KindPeriod   = 5'd11;
  localparam logic [4:0] KindArrow    = 5'd12;
  localparam logic [4:0] KindAmp      = 5'd13;
  localparam logic [4:0] KindStar     = 5'd14;
  localparam logic [4:0] KindAdd      = 5'd15;
  localparam logic [4:0] KindSub      = 5'd16;
  localparam logic [4:0] KindAssign   = 5'd17;
  localparam logic [4:0] KindAddAsg   = 5'd18;
  localparam logic [4:0] KindSubAsg   = 5'd19;
  localparam logic [4:0] KindEq       = 5'd20;
  localparam logic [4:0] KindNe       = 5'd21;
  localparam logic [4:0] KindIf       = 5'd22;
  localparam logic [4:0] KindElse     = 5'd23;
  localparam logic [4:0] KindWhile    = 5'd24;
  localparam logic [4:0] KindReturn   = 5'd25;
  localparam logic [4:0] KindStruct   = 5'd26;
  localparam logic [4:0] KindFn       = 5'd27;
  localparam logic [4:0] KindInt      = 5'd28;
  localparam logic [4:0] KindIdent    = 5'd29;
  localparam logic [4:0] KindErr      = 5'd30;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         token_kind;
    logic [PosBits-1:0] start_index;
    logic [PosBits-1:0] end_index;
    logic [PosBits-1:0] first_line;
    logic [PosBits-1:0] start_col;
    logic [PosBits-1:0] end_line;
    logic [PosBits-1:0] end_col;
    logic               last_of_run;
  } out_item_t;

  function automatic logic alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic num_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return num_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return alpha_ch(c) || num_ch(c) || c == "_";
  endfunction

  // keyword lookup on the first six bytes and the saturated length
  function automatic logic [4:0] word_kind(logic [47:0] w, logic [2:0] n);
    logic [4:0] k;
    k = KindIdent;
    if (n == 3'd2 && w == 48'h6966) k = KindIf;
    if (n == 3'd4 && w == 48'h656c7365) k = KindElse;
    if (n == 3'd5 && w == 48'h7768696c65) k = KindWhile;
    if (n == 3'd6 && w == 48'h72657475726e) k = KindReturn;
    if (n == 3'd6 && w == 48'h737472756374) k = KindStruct;
    if (n == 3'd2 && w == 48'h666e) k = KindFn;
    return k;
  endfunction

  function automatic logic [PosBits-1:0] sat_add(logic [PosBits-1:0] v,
                                                 logic [PosBits-1:0] d);
    logic [PosBits:0] s;
    s = {1'b0, v} + {1'b0, d};
    return s[PosBits] ? {PosBits{1'b1}} : s[PosBits-1:0];
  endfunction

endpackage

[design/source_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// source_token_lexer_unit
// streaming lexer, one source byte per item in, up to two tokens per byte out
// ----------------------------------------------------------------------------
// usage:
//   in channel: one source byte per item, last_byte marks the end of a source
//   and flushes the pending token; state then returns to the reset values
//   out channel: token items with kind, byte span and line/column span;
//   last_of_run marks the final token caused by one input byte
// timing: the tokens of a byte are written to the result register at the edge that accepts it
// throughput: one byte per cycle while the receiver takes every token; a byte
//   causing two tokens holds the input back while the two-entry result register
//   drains one token a cycle
// reset: lexer idle, index 0, line 1, column 1, output empty
// stall: the input is taken whenever the result register will be empty
//   after this edge, so a stalled receiver holds the input back one item
//   later; stalled payloads hold
// ----------------------------------------------------------------------------
module source_token_lexer_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  stl_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output stl_pkg::out_item_t   out_data_o
);
  import stl_pkg::*;

  localparam logic [3:0] MIdle  = 4'd0;
  localparam logic [3:0] MColon = 4'd1;
  localparam logic [3:0] MPlus  = 4'd2;
  localparam logic [3:0] MMinus = 4'd3;
  localparam logic [3:0] MBang  = 4'd4;
  localparam logic [3:0] MEqual = 4'd5;
  localparam logic [3:0] MSlash = 4'd6;
  localparam logic [3:0] MLine  = 4'd7;
  localparam logic [3:0] MBlock = 4'd8;
  localparam logic [3:0] MWord  = 4'd9;
  localparam logic [3:0] MZero  = 4'd10;
  localparam logic [3:0] MDec   = 4'd11;
  localparam logic [3:0] MHex   = 4'd12;
  localparam logic [3:0] MBin   = 4'd13;

  localparam logic [PosBits-1:0] One = PosBits'(1);
  localparam logic [DepthBits-1:0] MaxDepth = DepthBits'(MaxCommentDepth);

  // lexer state
  logic [3:0]           mode_q, mode_d;
  logic [PosBits-1:0]   pos_q, pos_d, line_q, line_d, col_q, col_d;
  logic [PosBits-1:0]   sp_q, sp_d, sl_q, sl_d, sc_q, sc_d;
  logic [DepthBits-1:0] depth_q, depth_d;
  logic [47:0]          wp_q, wp_d;
  logic [2:0]           wl_q, wl_d;
  logic [7:0]           pend_q, pend_d;

  // two-entry result register: slot 0 is shown, slot 1 waits behind it
  logic [1:0]  cnt_q, cnt_d;
  out_item_t   r0_q, r0_d, r1_q, r1_d;

  logic       take, pop;
  logic [7:0] c;
  logic       last;

  // tokens produced by this byte
  out_item_t  t0, t1;
  logic [1:0] nt;

  assign c    = in_data_i.char_byte;
  assign last = in_data_i.last_byte;
  assign pop  = out_valid_o && !out_stall_i;
  // accept only when the store is empty after this edge's pop
  assign in_stall_o = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall_i));
  assign take = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = r0_q;

  function automatic out_item_t mk(logic [4:0] k, logic [PosBits-1:0] sp,
                                   logic [PosBits-1:0] sl, logic [PosBits-1:0] sc,
                                   logic [PosBits-1:0] ep, logic [PosBits-1:0] el,
                                   logic [PosBits-1:0] ec);
    out_item_t o;
    o.token_kind = k; o.start_index = sp; o.end_index = ep;
    o.first_line = sl; o.start_col = sc; o.end_line = el; o.end_col = ec;
    o.last_of_run = 1'b0;
    return o;
  endfunction

  always_comb begin
    logic [4:0]         pk;
    logic               endp, idl, fin;
    logic [4:0]         ik;
    logic               iemit;
    logic [PosBits-1:0] psp, psl, psc, pm1;
    out_item_t          e;
    mode_d = mode_q; pos_d = pos_q; line_d = line_q; col_d = col_q;
    sp_d = sp_q; sl_d = sl_q; sc_d = sc_q; depth_d = depth_q;
    wp_d = wp_q; wl_d = wl_q; pend_d = pend_q;
    t0 = '0; t1 = '0; nt = 2'd0;
    endp = 1'b0; idl = 1'b0; ik = KindErr; iemit = 1'b0;
    pm1 = pos_q - One;

    case (mode_q)
      MPlus:  pk = KindAdd;
      MMinus: pk = KindSub;
      MEqual: pk = KindAssign;
      MWord:  pk = word_kind(wp_q, wl_q);
      MZero, MDec, MHex, MBin: pk = KindInt;
      default: pk = KindErr;
    endcase

    // two-character closers, emitted from the token start to this byte
    e = mk(KindErr, sp_q, sl_q, sc_q, pos_q, sl_q, sat_add(sc_q, pos_q - sp_q));

    case (mode_q)
      MIdle: idl = 1'b1;
      MColon: begin
        if (c == ":") begin e.token_kind = KindColCol; t0 = e; nt = 2'd1; mode_d = MIdle; end
        else if (c == "=") begin e.token_kind = KindColEq; t0 = e; nt = 2'd1; mode_d = MIdle; end
        else endp = 1'b1;
      end
      MPlus: begin
        if (c == "=") begin e.token_kind = KindAddAsg; t0 = e; nt = 2'd1; mode_d = MIdle; end
        else endp = 1'b1;
      end
      MMinus: begin
        if (c == ">") begin e.token_kind = KindArrow; t0 = e; nt = 2'd1; mode_d = MIdle; end
        else if (c == "=") begin e.token_kind = KindSubAsg; t0 = e; nt = 2'd1; mode_d = MIdle; end
        else endp = 1'b1;
      end
      MBang: begin
        if (c == "=") begin e.token_kind = KindNe; t0 = e; nt = 2'd1; mode_d = MIdle; end
        else endp = 1'b1;
      end
      MEqual: begin
        if (c == "=") begin e.token_kind = KindEq; t0 = e; nt = 2'd1; mode_d = MIdle; end
        else endp = 1'b1;
      end
      MSlash: begin
        if (c == "/") mode_d = MLine;
        else if (c == "*") begin mode_d = MBlock; depth_d = DepthBits'(1); pend_d = '0; end
        else endp = 1'b1;
      end
      MLine: if (c == 8'h0a) mode_d = MIdle;
      MBlock: begin
        if (pend_q == "/" && c == "*") begin
          pend_d = '0;
          if (depth_q >= MaxDepth) begin
            t0 = mk(KindErr, pm1, line_q, (col_q > One) ? col_q - One : One,
                    pos_q, line_q, col_q);
            nt = 2'd1;
          end else depth_d = depth_q + DepthBits'(1);
        end else if (pend_q == "*" && c == "/") begin
          pend_d = '0;
          if (depth_q > '0) depth_d = depth_q - DepthBits'(1);
          if (depth_q <= DepthBits'(1)) mode_d = MIdle;
        end else pend_d = (c == "*" || c == "/") ? c : 8'd0;
      end
      MWord: begin
        if (is_word(c)) begin
          if (wl_q < 3'd6) wp_d = {wp_q[39:0], c};
          if (wl_q < 3'd7) wl_d = wl_q + 3'd1;
        end else endp = 1'b1;
      end
      MZero: begin
        if (c == "x") mode_d = MHex;
        else if (c == "b") mode_d = MBin;
        else if (num_ch(c)) mode_d = MDec;
        else endp = 1'b1;
      end
      MDec: if (!num_ch(c)) endp = 1'b1;
      MHex: if (!is_hex(c)) endp = 1'b1;
      MBin: if (c != "0" && c != "1") endp = 1'b1;
      default: idl = 1'b1;
    endcase

    if (endp) begin
      t0 = mk(pk, sp_q, sl_q, sc_q, pm1, sl_q, sat_add(sc_q, pm1 - sp_q));
      nt = 2'd1;
      idl = 1'b1;
    end

    // handling of a byte between tokens
    if (idl) begin
      mode_d = MIdle;
      case (c)
        8'h20, 8'h09, 8'h0d, 8'h0a: ;
        "(": begin ik = KindLparen; iemit = 1'b1; end
        ")": begin ik = KindRparen; iemit = 1'b1; end
        "{": begin ik = KindLbrace; iemit = 1'b1; end
        "}": begin ik = KindRbrace; iemit = 1'b1; end
        "[": begin ik = KindLbrack; iemit = 1'b1; end
        "]": begin ik = KindRbrack; iemit = 1'b1; end
        ";": begin ik = KindSemi; iemit = 1'b1; end
        ",": begin ik = KindComma; iemit = 1'b1; end
        ".": begin ik = KindPeriod; iemit = 1'b1; end
        "&": begin ik = KindAmp; iemit = 1'b1; end
        "*": begin ik = KindStar; iemit = 1'b1; end
        ":": mode_d = MColon;
        "+": mode_d = MPlus;
        "-": mode_d = MMinus;
        "!": mode_d = MBang;
        "=": mode_d = MEqual;
        "/": mode_d = MSlash;
        default: begin
          if (alpha_ch(c) || c == "_") begin
            mode_d = MWord; wp_d = {40'd0, c}; wl_d = 3'd1;
          end else if (num_ch(c)) mode_d = (c == "0") ? MZero : MDec;
          else iemit = 1'b1;
        end
      endcase
      if (mode_d != MIdle || iemit) begin
        sp_d = pos_q; sl_d = line_q; sc_d = col_q;
      end
      if (iemit) begin
        e = mk(ik, pos_q, line_q, col_q, pos_q, line_q, col_q);
        if (nt == 2'd0) t0 = e; else t1 = e;
        nt = nt + 2'd1;
      end
    end

    // flush at the final byte
    psp = sp_d; psl = sl_d; psc = sc_d;
    case (mode_d)
      MPlus:  pk = KindAdd;
      MMinus: pk = KindSub;
      MEqual: pk = KindAssign;
      MWord:  pk = word_kind(wp_d, wl_d);
      MZero, MDec, MHex, MBin: pk = KindInt;
      default: pk = KindErr;
    endcase
    fin = 1'b0;
    if (last) begin
      if (mode_d == MBlock) begin
        if (depth_d > '0) begin
          e = mk(KindErr, psp, psl, psc, pos_q, line_q, col_q); fin = 1'b1;
        end
      end else if (mode_d != MIdle && mode_d != MLine) begin
        e = mk(pk, psp, psl, psc, pos_q, psl, sat_add(psc, pos_q - psp)); fin = 1'b1;
      end
      if (fin && nt < 2'd2) begin
        if (nt == 2'd0) t0 = e; else t1 = e;
        nt = nt + 2'd1;
      end
      mode_d = MIdle; pos_d = '0; line_d = One; col_d = One;
      sp_d = '0; sl_d = One; sc_d = One; depth_d = '0;
      wp_d = '0; wl_d = '0; pend_d = '0;
    end else begin
      pos_d = pos_q + One;
      if (c == 8'h0a) begin line_d = sat_add(line_q, One); col_d = One; end
      else col_d = sat_add(col_q, One);
    end

    if (nt == 2'd1) t0.last_of_run = 1'b1;
    if (nt == 2'd2) t1.last_of_run = 1'b1;
  end

  // result register update
  always_comb begin
    cnt_d = cnt_q; r0_d = r0_q; r1_d = r1_q;
    if (pop) begin
      r0_d = r1_q;
      cnt_d = cnt_q - 2'd1;
    end
    if (take && nt != 2'd0) begin
      // store is empty after pop whenever a byte is taken
      r0_d = t0; r1_d = t1; cnt_d = nt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; pos_q <= '0; line_q <= One; col_q <= One;
      sp_q <= '0; sl_q <= One; sc_q <= One; depth_q <= '0;
      wp_q <= '0; wl_q <= '0; pend_q <= '0; cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (take) begin
        mode_q <= mode_d; pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
        sp_q <= sp_d; sl_q <= sl_d; sc_q <= sc_d; depth_q <= depth_d;
        wp_q <= wp_d; wl_q <= wl_d; pend_q <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

  // two results are stored only when the first is not yet the last
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result count out of range");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !r0_q.last_of_run && r1_q.last_of_run)
    else $error("queued pair marked wrong");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> in_stall_o) else $error("input taken with store full");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= MaxDepth) else $error("comment depth over bound");

endmodule
